// File: rtl/text_console_cell_writer_assert.svh
// Assertion macros for the text console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCCW_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: rtl/tccw_pkg.sv
// Shared types, codes and the colour letter lookup for the console cell writer.
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 5;
   localparam int INDEX_W  = 11;
   localparam int BYTE_W   = 8;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ACT_PLAIN   = 2'd0,
      ACT_FORMAT  = 2'd1,
      ACT_NEWLINE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_G       = 8'h67;
   localparam logic [BYTE_W-1:0] CHAR_B       = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_W       = 8'h77;
   localparam logic [BYTE_W-1:0] CHAR_C       = 8'h63;
   localparam logic [BYTE_W-1:0] CHAR_R       = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_M       = 8'h6d;
   localparam logic [BYTE_W-1:0] CHAR_Y       = 8'h79;
   localparam logic [BYTE_W-1:0] CHAR_N       = 8'h6e;

   localparam logic [BYTE_W-1:0] COLOUR_DEFAULT = 8'h07;
   localparam logic [BYTE_W-1:0] COLOUR_GREEN   = 8'h0a;
   localparam logic [BYTE_W-1:0] COLOUR_BLUE    = 8'h09;
   localparam logic [BYTE_W-1:0] COLOUR_WHITE   = 8'h0f;
   localparam logic [BYTE_W-1:0] COLOUR_CYAN    = 8'h0b;
   localparam logic [BYTE_W-1:0] COLOUR_RED     = 8'h0c;
   localparam logic [BYTE_W-1:0] COLOUR_MAGENTA = 8'h0d;
   localparam logic [BYTE_W-1:0] COLOUR_YELLOW  = 8'h0e;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] cell_index;
      logic [BYTE_W-1:0]  glyph;
      logic [BYTE_W-1:0]  attribute;
      logic               last;
   } rsp_type;

   // Results of one input transaction; second is only used when two is set.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } batch_type;

   function automatic logic [BYTE_W-1:0] colour_for(input logic [BYTE_W-1:0] ch,
                                                    input logic [BYTE_W-1:0] old);
      logic [BYTE_W-1:0] colour;
      unique case (ch)
         CHAR_G:  colour = COLOUR_GREEN;
         CHAR_B:  colour = COLOUR_BLUE;
         CHAR_W:  colour = COLOUR_WHITE;
         CHAR_C:  colour = COLOUR_CYAN;
         CHAR_R:  colour = COLOUR_RED;
         CHAR_M:  colour = COLOUR_MAGENTA;
         CHAR_Y:  colour = COLOUR_YELLOW;
         CHAR_N:  colour = COLOUR_DEFAULT;
         default: colour = old;
      endcase
      return colour;
   endfunction

endpackage

// File: rtl/tccw_engine.sv
// Cursor, colour and escape state with the per-transaction result logic.
`timescale 1ns / 1ps

module tccw_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  action,
   input  logic [tccw_pkg::BYTE_W-1:0] character,
   input  logic                        string_start,
   output tccw_pkg::batch_type         batch,
   output logic                        batch_push
);

   logic [tccw_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [tccw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tccw_pkg::BYTE_W-1:0]   colour_ff, colour_in;
   logic                          escape_ff, escape_in;

   tccw_pkg::action_type        act;
   logic [tccw_pkg::BYTE_W-1:0] colour_eff;
   logic                        escape_eff;
   logic                        is_lf;
   logic                        is_percent;
   logic                        char_path;
   logic                        do_write;
   logic                        do_newline;
   logic                        do_clear;
   logic [tccw_pkg::COLUMN_W:0] column_inc;
   logic [tccw_pkg::ROW_W:0]    row_inc;
   logic                        column_wrap;
   logic                        row_wrap;
   logic [tccw_pkg::INDEX_W:0]  index_full;
   tccw_pkg::rsp_type           write_rsp;
   tccw_pkg::rsp_type           clear_rsp;

   always_comb begin
      act        = tccw_pkg::action_type'(action);
      colour_eff = string_start ? tccw_pkg::COLOUR_DEFAULT : colour_ff;
      escape_eff = string_start ? 1'b0 : escape_ff;
      is_lf      = (character == tccw_pkg::CHAR_LF);
      is_percent = (character == tccw_pkg::CHAR_PERCENT);

      char_path  = (act == tccw_pkg::ACT_PLAIN) ||
                   ((act == tccw_pkg::ACT_FORMAT) && !escape_eff && !is_percent);
      do_write   = char_path && !is_lf;

      column_inc  = {1'b0, column_ff} + (tccw_pkg::COLUMN_W+1)'(1);
      row_inc     = {1'b0, row_ff} + (tccw_pkg::ROW_W+1)'(1);
      column_wrap = (column_inc >= (tccw_pkg::COLUMN_W+1)'(COLUMNS));
      row_wrap    = (row_inc >= (tccw_pkg::ROW_W+1)'(ROWS));

      do_newline = (act == tccw_pkg::ACT_NEWLINE) || (char_path && is_lf) ||
                   (do_write && column_wrap);
      do_clear   = (act == tccw_pkg::ACT_CLEAR) || (do_newline && row_wrap);

      index_full = (tccw_pkg::INDEX_W+1)'(row_ff) * (tccw_pkg::INDEX_W+1)'(COLUMNS) +
                   (tccw_pkg::INDEX_W+1)'(column_ff);

      write_rsp.kind       = tccw_pkg::KIND_WRITE;
      write_rsp.cell_index = index_full[tccw_pkg::INDEX_W-1:0];
      write_rsp.glyph      = character;
      write_rsp.attribute  = (act == tccw_pkg::ACT_PLAIN) ? tccw_pkg::COLOUR_DEFAULT
                                                          : colour_eff;
      write_rsp.last       = !do_clear;

      clear_rsp.kind       = tccw_pkg::KIND_CLEAR;
      clear_rsp.cell_index = '0;
      clear_rsp.glyph      = '0;
      clear_rsp.attribute  = '0;
      clear_rsp.last       = 1'b1;

      batch.two    = do_write && do_clear;
      batch.first  = do_write ? write_rsp : clear_rsp;
      batch.second = clear_rsp;
      batch_push   = accept && (do_write || do_clear);

      priority if (do_clear) begin
         column_in = '0;
         row_in    = '0;
      end else if (do_newline) begin
         column_in = '0;
         row_in    = row_inc[tccw_pkg::ROW_W-1:0];
      end else if (do_write) begin
         column_in = column_inc[tccw_pkg::COLUMN_W-1:0];
         row_in    = row_ff;
      end else begin
         column_in = column_ff;
         row_in    = row_ff;
      end

      colour_in = ((act == tccw_pkg::ACT_FORMAT) && escape_eff) ?
                  tccw_pkg::colour_for(character, colour_eff) : colour_eff;
      escape_in = (act == tccw_pkg::ACT_FORMAT) && !escape_eff && is_percent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         colour_ff <= tccw_pkg::COLOUR_DEFAULT;
         escape_ff <= 1'b0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         colour_ff <= colour_in;
         escape_ff <= escape_in;
      end
   end

endmodule

// File: rtl/tccw_rsp_queue.sv
// Result register queue: holds result batches and hands them out one transaction at a time.
`timescale 1ns / 1ps

module tccw_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tccw_pkg::batch_type batch,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tccw_pkg::rsp_type   rsp
);

   localparam int PTR_W = (tccw_pkg::QUEUE_DEPTH > 1) ? $clog2(tccw_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tccw_pkg::QUEUE_DEPTH + 1);

   tccw_pkg::batch_type mem [tccw_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sub_ff, sub_in;

   tccw_pkg::batch_type head;
   logic                pop;
   logic                retire;

   always_comb begin
      head      = mem[rd_ptr_ff];
      rsp_valid = (count_ff != '0);
      rsp       = sub_ff ? head.second : head.first;
      full      = (count_ff == CNT_W'(tccw_pkg::QUEUE_DEPTH));
      pop       = rsp_valid && rsp_ready;
      retire    = pop && (!head.two || sub_ff);

      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = retire ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(retire);
      sub_in    = retire ? 1'b0 : (pop ? 1'b1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= batch;
      end
   end

endmodule

// File: rtl/text_console_cell_writer.sv
// Text console cell writer top level.
//
// Input channel req_*: one character, newline or clear command per transaction.
// Result channel rsp_*: cell writes and clear-screen commands, rsp_last marking
// the final result of an input transaction; some inputs give no result.
// The cursor, colour and escape state update in the cycle the input is taken,
// and the results land in a two-entry result queue, whose registers offer
// them on rsp_* in order once earlier results have gone. One input per cycle
// is sustained while each input gives at most one result and rsp_ready stays
// high; an input giving a cell write plus a clear holds the result port for
// both results. The queue depth sets how far the input side runs ahead of a
// stalled receiver: req_ready drops once results of two inputs are waiting.
// Reset (synchronous) homes the cursor, sets colour 0x07, clears the escape
// flag and empties the queue.
`timescale 1ns / 1ps
`include "text_console_cell_writer_assert.svh"

module text_console_cell_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [tccw_pkg::BYTE_W-1:0]  req_character,
   input  logic                         req_string_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kind,
   output logic [tccw_pkg::INDEX_W-1:0] rsp_cell_index,
   output logic [tccw_pkg::BYTE_W-1:0]  rsp_glyph,
   output logic [tccw_pkg::BYTE_W-1:0]  rsp_attribute,
   output logic                         rsp_last
);

   logic                accept;
   logic                queue_full;
   logic                batch_push;
   tccw_pkg::batch_type batch;
   tccw_pkg::rsp_type   rsp;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   tccw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_action),
      .character    (req_character),
      .string_start (req_string_start),
      .batch        (batch),
      .batch_push   (batch_push)
   );

   tccw_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (batch_push),
      .batch     (batch),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind       = rsp.kind;
   assign rsp_cell_index = rsp.cell_index;
   assign rsp_glyph      = rsp.glyph;
   assign rsp_attribute  = rsp.attribute;
   assign rsp_last       = rsp.last;

   `TCCW_ASSERT_NOW(a_clear_zero, clock, reset,
      rsp_valid && (rsp_kind == tccw_pkg::KIND_CLEAR),
      (rsp_cell_index == '0) && (rsp_glyph == '0) && (rsp_attribute == '0) && rsp_last,
      "clear result carries non-zero payload")

   `TCCW_ASSERT_NOW(a_index_range, clock, reset,
      rsp_valid && (rsp_kind == tccw_pkg::KIND_WRITE) && (ROWS * COLUMNS <= 2048),
      {1'b0, rsp_cell_index} < 12'(ROWS * COLUMNS),
      "cell write outside the screen")

   `TCCW_ASSERT_NOW(a_pair_order, clock, reset,
      batch_push && batch.two,
      (batch.first.kind == tccw_pkg::KIND_WRITE) && !batch.first.last &&
      (batch.second.kind == tccw_pkg::KIND_CLEAR) && batch.second.last,
      "two-result transaction not a write followed by a clear")

   `TCCW_ASSERT_NEXT(a_rest_follows, clock, reset,
      rsp_valid && rsp_ready && !rsp_last,
      rsp_valid,
      "second result of a transaction went missing")

endmodule
